// File: rtl/pfla_pkg.sv
package pfla_pkg;

  // Field widths of the stream and configuration payloads
  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 22;
  localparam int REG_W   = 23;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  // Defaults for the top level parameters
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int DEF_NUM_PAGES  = 1024;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RANGE  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP   = 1'd1;

  // Register reset values
  localparam logic [REG_W-1:0] HEAP_START_RST = 23'd0;
  localparam logic [REG_W-1:0] PHYS_TOP_RST   = 23'd4194304;

endpackage

// File: rtl/pfla_link_ram.sv
module pfla_link_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 11,
  parameter int AW     = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/page_free_list_allocator.sv
// Page frame allocator: a LIFO free list of physical pages, one link word per page
// kept in a single-port-write, registered-read link memory.
//
// Input channel (in_*): one beat carries a command. Allocate pops the list head and
// returns its byte address; free checks one page address and pushes it; range free
// rounds the start up to a page boundary and pushes every whole page below the end,
// stopping at the first page that fails the check.
// Result channel (out_*): exactly one beat per command: status, page address, count.
// Configuration channel (cfg_*): always ready; index 0 writes heap_start, 1 phys_top.
// Write it only while no command is in flight.
//
// Sequencing: allocate and single free do at most one link memory read or write between
// accept and result; range free does one link write per page pushed, since the link
// memory takes one write per cycle. Commands run one at a time; in_tready is
// high whenever the engine is free, even if a result still waits in the output
// register. If the receiver stalls, a finished result parks in a holding register
// and the engine waits there until the output register drains.
// Reset leaves the list empty and the registers at their reset values; the link
// memory is not cleared, since only pushed pages are ever read.
module page_free_list_allocator
  import pfla_pkg::*;
#(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int NUM_PAGES  = DEF_NUM_PAGES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: cmd[1:0], addr[23:2], range_end[46:24], zero pad [47]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tdata: status[1:0], page_addr[23:2], pages_freed[34:24], zero pad [39:35]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  localparam int IDX_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int LINK_W    = IDX_W + 1;
  localparam int PAGE_BITS = $clog2(PAGE_BYTES);
  localparam logic [REG_W-1:0] PAGE_MASK  = REG_W'(PAGE_BYTES - 1);
  localparam logic [REG_W:0]   PAGE_STEP  = (REG_W + 1)'(PAGE_BYTES);
  localparam logic [REG_W:0]   NPAGES_LIM = (REG_W + 1)'(NUM_PAGES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_RANGE,
    S_HOLD
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    head_index_r, head_index_nxt;
  logic                head_valid_r, head_valid_nxt;
  logic [REG_W-1:0]    heap_start_r, phys_top_r;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [REG_W-1:0]    rend_r, rend_nxt;
  logic [REG_W-1:0]    p_r, p_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]   res_paddr_r, res_paddr_nxt;
  logic [CNT_W-1:0]    res_count_r, res_count_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_paddr_r, out_paddr_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;

  logic                in_fire, out_free;
  logic [CMD_W-1:0]    in_cmd;
  logic [ADDR_W-1:0]   in_addr;
  logic [REG_W-1:0]    in_rend;
  logic [REG_W-1:0]    round_sum;
  logic [REG_W:0]      p_end;
  logic [IDX_W+REG_W-1:0] head_bytes;

  logic                mem_we, mem_re;
  logic [IDX_W-1:0]    mem_wa;
  logic [LINK_W-1:0]   mem_wd;
  logic [LINK_W-1:0]   mem_rd;

  logic                push_en;
  logic [REG_W-1:0]    push_addr;
  logic                fin_en;
  logic [STAT_W-1:0]   fin_status;
  logic [ADDR_W-1:0]   fin_paddr;
  logic [CNT_W-1:0]    fin_count;

  // Page check: inside [heap_start, phys_top), aligned, index below the page count
  function automatic logic page_ok(input logic [REG_W-1:0] a,
                                   input logic [REG_W-1:0] lo,
                                   input logic [REG_W-1:0] hi);
    logic [REG_W:0] idx;
    idx = {1'b0, a >> PAGE_BITS};
    return (a >= lo) && (a < hi) && ((a & PAGE_MASK) == '0) && (idx < NPAGES_LIM);
  endfunction

  assign in_cmd  = in_tdata[1:0];
  assign in_addr = in_tdata[23:2];
  assign in_rend = in_tdata[46:24];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Round the range start up to a page boundary
  assign round_sum = ({1'b0, in_addr} + PAGE_MASK) & ~PAGE_MASK;
  assign p_end     = {1'b0, p_r} + PAGE_STEP;
  assign head_bytes = (IDX_W + REG_W)'(head_index_r) << PAGE_BITS;

  // Link memory: read the head's link on allocate, write one link per push
  assign mem_re = in_fire && (in_cmd == CMD_ALLOC);
  assign mem_we = push_en;
  assign mem_wa = IDX_W'(push_addr >> PAGE_BITS);
  assign mem_wd = head_valid_r ? (LINK_W'(head_index_r) + LINK_W'(1)) : '0;

  pfla_link_ram #(
    .DEPTH  (NUM_PAGES),
    .DATA_W (LINK_W),
    .AW     (IDX_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (head_index_r),
    .rdata (mem_rd)
  );

  always_comb begin
    state_nxt      = state_r;
    head_index_nxt = head_index_r;
    head_valid_nxt = head_valid_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    rend_nxt       = rend_r;
    p_nxt          = p_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_paddr_nxt  = res_paddr_r;
    res_count_nxt  = res_count_r;
    out_status_nxt = out_status_r;
    out_paddr_nxt  = out_paddr_r;
    out_count_nxt  = out_count_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    push_en        = 1'b0;
    push_addr      = p_r;
    fin_en         = 1'b0;
    fin_status     = STAT_OK;
    fin_paddr      = '0;
    fin_count      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt  = in_cmd;
          addr_nxt = in_addr;
          rend_nxt = in_rend;
          p_nxt    = round_sum;
          cnt_nxt  = '0;
          case (in_cmd)
            CMD_ALLOC: state_nxt = S_ALLOC;
            CMD_RANGE: state_nxt = S_RANGE;
            default:   state_nxt = S_FREE;
          endcase
        end
      end
      S_ALLOC: begin
        fin_en = 1'b1;
        if (head_valid_r) begin
          fin_paddr = head_bytes[ADDR_W-1:0];
          if (mem_rd == '0) begin
            head_valid_nxt = 1'b0;
            head_index_nxt = '0;
          end else begin
            head_index_nxt = IDX_W'(mem_rd - LINK_W'(1));
          end
        end else begin
          fin_status = STAT_EMPTY;
        end
      end
      S_FREE: begin
        fin_en    = 1'b1;
        push_addr = {1'b0, addr_r};
        if (cmd_r == CMD_FREE) begin
          if (page_ok({1'b0, addr_r}, heap_start_r, phys_top_r)) begin
            push_en   = 1'b1;
            fin_count = CNT_W'(1);
          end else begin
            fin_status = STAT_BAD;
          end
        end
      end
      S_RANGE: begin
        if (p_end <= {1'b0, rend_r}) begin
          if (page_ok(p_r, heap_start_r, phys_top_r)) begin
            push_en = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
            p_nxt   = p_end[REG_W-1:0];
          end else begin
            fin_en     = 1'b1;
            fin_status = STAT_BAD;
            fin_count  = cnt_r;
          end
        end else begin
          fin_en    = 1'b1;
          fin_count = cnt_r;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_status_nxt = res_status_r;
          out_paddr_nxt  = res_paddr_r;
          out_count_nxt  = res_count_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Push the page onto the list head
    if (push_en) begin
      head_index_nxt = mem_wa;
      head_valid_nxt = 1'b1;
    end

    // Hand the result to the output register, or park it if the receiver stalls
    if (fin_en) begin
      if (out_free) begin
        out_status_nxt = fin_status;
        out_paddr_nxt  = fin_paddr;
        out_count_nxt  = fin_count;
        out_tvalid_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end else begin
        res_status_nxt = fin_status;
        res_paddr_nxt  = fin_paddr;
        res_count_nxt  = fin_count;
        state_nxt      = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_index_r <= '0;
      head_valid_r <= 1'b0;
      out_tvalid_r <= 1'b0;
      heap_start_r <= HEAP_START_RST;
      phys_top_r   <= PHYS_TOP_RST;
    end else begin
      state_r      <= state_nxt;
      head_index_r <= head_index_nxt;
      head_valid_r <= head_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEAP_START: heap_start_r <= cfg_data;
          CFG_PHYS_TOP:   phys_top_r   <= cfg_data;
          default: ;
        endcase
      end
    end
    cmd_r        <= cmd_nxt;
    addr_r       <= addr_nxt;
    rend_r       <= rend_nxt;
    p_r          <= p_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_paddr_r  <= res_paddr_nxt;
    res_count_r  <= res_count_nxt;
    out_status_r <= out_status_nxt;
    out_paddr_r  <= out_paddr_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_count_r, out_paddr_r, out_status_r};

  // Link memory writes only come from a push
  a_write_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_FREE || state_r == S_RANGE))
    else $error("link write outside a free command");

  // An accepted allocate reads the link and resolves in the next cycle
  a_alloc_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == CMD_ALLOC) |=> (state_r == S_ALLOC))
    else $error("allocate did not advance to the pop step");

  // Only a pop empties the list
  a_empty_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(head_valid_r) |-> ($past(state_r) == S_ALLOC))
    else $error("list emptied outside an allocate");

  // A result appears only after a command was worked on
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) != S_IDLE))
    else $error("result produced without a command");

  // The head always names a managed page
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid_r |-> ((REG_W + 1)'(head_index_r) < NPAGES_LIM))
    else $error("list head beyond page count");

endmodule
